@@ rtl/psu_pkg.sv @@
// Shared constants, types and the Paeth predictor for the PNG scanline unfilter.
package psu_pkg;

    // Default build limits
    localparam int DEF_MAX_WIDTH = 4096;
    localparam int DEF_MAX_BPP   = 4;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BYTES_PER_PIXEL = 2'd2;

    // Register and field widths
    localparam int WIDTH_CFG_W  = 13;
    localparam int HEIGHT_CFG_W = 16;
    localparam int BPP_CFG_W    = 3;
    localparam int BYTE_W       = 8;

    // Filter type codes
    localparam logic [BYTE_W-1:0] FILT_NONE  = 8'd0;
    localparam logic [BYTE_W-1:0] FILT_SUB   = 8'd1;
    localparam logic [BYTE_W-1:0] FILT_UP    = 8'd2;
    localparam logic [BYTE_W-1:0] FILT_AVG   = 8'd3;
    localparam logic [BYTE_W-1:0] FILT_PAETH = 8'd4;

    // Per-transaction control decided at the front end
    typedef struct packed {
        logic is_filter;
        logic first_row;
        logic row_end;
        logic image_end;
    } psu_ctrl_t;

    function automatic logic [BYTE_W-1:0] paeth_pick(input logic [BYTE_W-1:0] a,
                                                     input logic [BYTE_W-1:0] b,
                                                     input logic [BYTE_W-1:0] c);
        logic signed [9:0] pa;
        logic signed [9:0] pb;
        logic signed [9:0] pc;
        logic [9:0]        da;
        logic [9:0]        db;
        logic [9:0]        dc;
        logic [BYTE_W-1:0] pick;
        pa = $signed({2'b00, b}) - $signed({2'b00, c});
        pb = $signed({2'b00, a}) - $signed({2'b00, c});
        pc = $signed({2'b00, a}) + $signed({2'b00, b}) - $signed({1'b0, c, 1'b0});
        da = (pa < 0) ? 10'(-pa) : 10'(pa);
        db = (pb < 0) ? 10'(-pb) : 10'(pb);
        dc = (pc < 0) ? 10'(-pc) : 10'(pc);
        if (da <= db && da <= dc) begin
            pick = a;
        end else if (db <= dc) begin
            pick = b;
        end else begin
            pick = c;
        end
        return pick;
    endfunction

endpackage

@@ rtl/psu_row_mem.sv @@
// Prior-row byte store: one write port, one registered read port.
module psu_row_mem
    import psu_pkg::*;
#(
    parameter int DEPTH = DEF_MAX_WIDTH * DEF_MAX_BPP
) (
    input  logic                              aclk,
    input  logic                              rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [BYTE_W-1:0]                 rd_data,
    input  logic                              wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [BYTE_W-1:0]                 wr_data
);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold read data when no read is issued; the consumer may stall
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ rtl/psu_ctrl.sv @@
// Front-end sequencer: config registers, row/column counters and slot lanes.
module psu_ctrl
    import psu_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int MAX_BPP   = DEF_MAX_BPP,
    localparam int ROW_STORE = MAX_WIDTH * MAX_BPP,
    localparam int COL_W     = (ROW_STORE > 1) ? $clog2(ROW_STORE) : 1,
    localparam int SLOT_W    = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    input  logic                  accept,
    output psu_ctrl_t             item_ctrl,
    output logic [COL_W-1:0]      item_col,
    output logic [SLOT_W-1:0]     item_slot
);

    localparam int W_W   = $clog2(MAX_WIDTH + 1);
    localparam int BPP_W = $clog2(MAX_BPP + 1);
    localparam int RB_W  = $clog2(ROW_STORE + 1);

    logic [WIDTH_CFG_W-1:0]  width_reg;
    logic [HEIGHT_CFG_W-1:0] height_reg;
    logic [BPP_CFG_W-1:0]    bpp_reg;

    logic                    awaiting_reg, awaiting_next;
    logic                    first_row_reg, first_row_next;
    logic [COL_W-1:0]        col_reg, col_next;
    logic [HEIGHT_CFG_W-1:0] row_reg, row_next;
    logic [SLOT_W-1:0]       slot_reg  [MAX_BPP];
    logic [SLOT_W-1:0]       slot_next [MAX_BPP];

    logic [W_W-1:0]          w_eff;
    logic [BPP_W-1:0]        bpp_eff;
    logic [HEIGHT_CFG_W-1:0] h_eff;
    logic [RB_W-1:0]         row_bytes;
    logic [RB_W-1:0]         col_inc;
    logic                    row_end;
    logic                    image_end;

    // Clamp registers to the supported range
    always_comb begin
        if (width_reg == '0) begin
            w_eff = W_W'(1);
        end else if (32'(width_reg) > MAX_WIDTH) begin
            w_eff = W_W'(MAX_WIDTH);
        end else begin
            w_eff = W_W'(width_reg);
        end
        if (bpp_reg == '0) begin
            bpp_eff = BPP_W'(1);
        end else if (32'(bpp_reg) > MAX_BPP) begin
            bpp_eff = BPP_W'(MAX_BPP);
        end else begin
            bpp_eff = BPP_W'(bpp_reg);
        end
        h_eff = (height_reg == '0) ? HEIGHT_CFG_W'(1) : height_reg;
    end

    assign row_bytes = RB_W'(w_eff) * RB_W'(bpp_eff);
    assign col_inc   = RB_W'(col_reg) + RB_W'(1);
    assign row_end   = col_inc >= row_bytes;
    assign image_end = row_end &&
                       ((17'(row_reg) + 17'd1) >= {1'b0, h_eff});

    assign item_ctrl.is_filter = awaiting_reg;
    assign item_ctrl.first_row = first_row_reg;
    assign item_ctrl.row_end   = row_end;
    assign item_ctrl.image_end = image_end;
    assign item_col            = col_reg;
    assign item_slot           = slot_reg[SLOT_W'(bpp_eff - BPP_W'(1))];

    always_comb begin
        awaiting_next  = awaiting_reg;
        first_row_next = first_row_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        for (int k = 0; k < MAX_BPP; k++) begin
            slot_next[k] = slot_reg[k];
        end
        if (accept) begin
            if (awaiting_reg) begin
                awaiting_next = 1'b0;
                col_next      = '0;
                for (int k = 0; k < MAX_BPP; k++) begin
                    slot_next[k] = '0;
                end
            end else if (row_end) begin
                awaiting_next = 1'b1;
                col_next      = '0;
                if (image_end) begin
                    row_next       = '0;
                    first_row_next = 1'b1;
                end else begin
                    row_next       = row_reg + HEIGHT_CFG_W'(1);
                    first_row_next = 1'b0;
                end
            end else begin
                col_next = col_reg + COL_W'(1);
                // Each lane counts the column modulo its own pixel size
                for (int k = 0; k < MAX_BPP; k++) begin
                    slot_next[k] = (slot_reg[k] == SLOT_W'(k)) ? '0
                                                              : slot_reg[k] + SLOT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg     <= WIDTH_CFG_W'(1);
            height_reg    <= HEIGHT_CFG_W'(1);
            bpp_reg       <= BPP_CFG_W'(4);
            awaiting_reg  <= 1'b1;
            first_row_reg <= 1'b1;
            col_reg       <= '0;
            row_reg       <= '0;
            for (int k = 0; k < MAX_BPP; k++) begin
                slot_reg[k] <= '0;
            end
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    REG_IMAGE_WIDTH:     width_reg  <= cfg_wr_data[WIDTH_CFG_W-1:0];
                    REG_IMAGE_HEIGHT:    height_reg <= cfg_wr_data[HEIGHT_CFG_W-1:0];
                    REG_BYTES_PER_PIXEL: bpp_reg    <= cfg_wr_data[BPP_CFG_W-1:0];
                    default: begin
                    end
                endcase
            end
            awaiting_reg  <= awaiting_next;
            first_row_reg <= first_row_next;
            col_reg       <= col_next;
            row_reg       <= row_next;
            for (int k = 0; k < MAX_BPP; k++) begin
                slot_reg[k] <= slot_next[k];
            end
        end
    end

endmodule

@@ rtl/psu_recon.sv @@
// Reconstruction stage: predictor, pixel rings, prior-row write-back, output register.
module psu_recon
    import psu_pkg::*;
#(
    parameter int MAX_WIDTH = DEF_MAX_WIDTH,
    parameter int MAX_BPP   = DEF_MAX_BPP,
    localparam int ROW_STORE = MAX_WIDTH * MAX_BPP,
    localparam int COL_W     = (ROW_STORE > 1) ? $clog2(ROW_STORE) : 1,
    localparam int SLOT_W    = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  logic [BYTE_W-1:0] in_byte,
    input  psu_ctrl_t         in_ctrl,
    input  logic [COL_W-1:0]  in_col,
    input  logic [SLOT_W-1:0] in_slot,
    input  logic [BYTE_W-1:0] above_byte,
    output logic              stage_free,
    output logic              stage_busy,
    output logic              wr_en,
    output logic [COL_W-1:0]  wr_addr,
    output logic [BYTE_W-1:0] wr_data,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [BYTE_W-1:0] m_pixel_byte,
    output logic              m_end_of_row,
    output logic              m_last_of_image
);

    logic              s1_valid_reg, s1_valid_next;
    logic [BYTE_W-1:0] s1_byte_reg;
    psu_ctrl_t         s1_ctrl_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic [SLOT_W-1:0] s1_slot_reg;

    logic [BYTE_W-1:0] row_filter_reg;
    logic [BYTE_W-1:0] left_reg  [MAX_BPP];
    logic [BYTE_W-1:0] upper_reg [MAX_BPP];

    logic              out_valid_reg, out_valid_next;
    logic [BYTE_W-1:0] out_byte_reg;
    logic              out_eor_reg;
    logic              out_last_reg;

    logic              out_free;
    logic              advance;
    logic              pix_advance;
    logic              filt_advance;
    logic [BYTE_W-1:0] a_byte, b_byte, c_byte;
    logic [BYTE_W-1:0] avg_byte;
    logic [BYTE_W-1:0] pred;
    logic [BYTE_W-1:0] val;

    assign out_free     = !out_valid_reg || m_ready;
    assign advance      = s1_valid_reg && (s1_ctrl_reg.is_filter || out_free);
    assign pix_advance  = advance && !s1_ctrl_reg.is_filter;
    assign filt_advance = advance && s1_ctrl_reg.is_filter;
    assign stage_free   = !s1_valid_reg || advance;
    assign stage_busy   = s1_valid_reg;

    assign a_byte   = left_reg[s1_slot_reg];
    assign c_byte   = upper_reg[s1_slot_reg];
    assign b_byte   = s1_ctrl_reg.first_row ? '0 : above_byte;
    assign avg_byte = BYTE_W'(({1'b0, a_byte} + {1'b0, b_byte}) >> 1);

    always_comb begin
        unique case (row_filter_reg)
            FILT_NONE:  pred = '0;
            FILT_SUB:   pred = a_byte;
            FILT_UP:    pred = b_byte;
            FILT_AVG:   pred = avg_byte;
            FILT_PAETH: pred = paeth_pick(a_byte, b_byte, c_byte);
            default:    pred = '0;
        endcase
        // Unknown filter types zero the whole row
        val = (row_filter_reg <= FILT_PAETH) ? s1_byte_reg + pred : '0;
    end

    assign wr_en   = pix_advance;
    assign wr_addr = s1_col_reg;
    assign wr_data = val;

    assign s1_valid_next  = load || (s1_valid_reg && !advance);
    assign out_valid_next = pix_advance || (out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            row_filter_reg <= FILT_NONE;
            for (int k = 0; k < MAX_BPP; k++) begin
                left_reg[k]  <= '0;
                upper_reg[k] <= '0;
            end
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (filt_advance) begin
                row_filter_reg <= s1_byte_reg;
                for (int k = 0; k < MAX_BPP; k++) begin
                    left_reg[k]  <= '0;
                    upper_reg[k] <= '0;
                end
            end else if (pix_advance) begin
                upper_reg[s1_slot_reg] <= b_byte;
                left_reg[s1_slot_reg]  <= val;
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (load) begin
            s1_byte_reg <= in_byte;
            s1_ctrl_reg <= in_ctrl;
            s1_col_reg  <= in_col;
            s1_slot_reg <= in_slot;
        end
        if (pix_advance) begin
            out_byte_reg <= val;
            out_eor_reg  <= s1_ctrl_reg.row_end;
            out_last_reg <= s1_ctrl_reg.image_end;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_pixel_byte    = out_byte_reg;
    assign m_end_of_row    = out_eor_reg;
    assign m_last_of_image = out_last_reg;

endmodule

@@ rtl/png_scanline_unfilter_top.sv @@
// PNG scanline unfilter top level: handshake, sequencer, row store and reconstruction.
// An accepted pixel byte passes the stage register, then the output register on m_*.
// Throughput: one byte (filter or pixel) per cycle unless m_ready holds the output; set
//   by the one registered row-store read issued at accept and the one reconstruction
//   stage that consumes it. Filter bytes produce no output transaction.
// Reset (aresetn low, synchronous) clears counters, rings and valids and restores the
//   register defaults; the row store is not cleared and needs no clearing pass.
module png_scanline_unfilter_top
    import psu_pkg::*;
#(
    parameter int MAX_WIDTH           = DEF_MAX_WIDTH,
    parameter int MAX_BYTES_PER_PIXEL = DEF_MAX_BPP
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    // configuration writes
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wr_data,
    // filtered stream in
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [BYTE_W-1:0]     s_data_byte,
    // reconstructed bytes out
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [BYTE_W-1:0]     m_pixel_byte,
    output logic                  m_end_of_row,
    output logic                  m_last_of_image
);

    localparam int ROW_STORE = MAX_WIDTH * MAX_BYTES_PER_PIXEL;
    localparam int COL_W     = (ROW_STORE > 1) ? $clog2(ROW_STORE) : 1;
    localparam int SLOT_W    = (MAX_BYTES_PER_PIXEL > 1) ? $clog2(MAX_BYTES_PER_PIXEL) : 1;

    psu_ctrl_t         item_ctrl;
    logic [COL_W-1:0]  item_col;
    logic [SLOT_W-1:0] item_slot;
    logic              accept;
    logic              stage_free;
    logic              stage_busy;
    logic              rd_en;
    logic [BYTE_W-1:0] above_byte;
    logic              wr_en;
    logic [COL_W-1:0]  wr_addr;
    logic [BYTE_W-1:0] wr_data;

    // Take a transaction whenever the reconstruction stage empties this cycle
    assign s_ready = stage_free;
    assign accept  = s_valid && s_ready;

    // Fetch the byte above only for pixel transactions; filter bytes leave it alone
    assign rd_en = accept && !item_ctrl.is_filter;

    psu_ctrl #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_BPP   (MAX_BYTES_PER_PIXEL)
    ) u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .accept      (accept),
        .item_ctrl   (item_ctrl),
        .item_col    (item_col),
        .item_slot   (item_slot)
    );

    // A column is rewritten by the stage before its next read comes around: the
    // same column of the next row is at least two transactions later (filter byte
    // in between), so no forwarding path is needed.
    psu_row_mem #(
        .DEPTH (ROW_STORE)
    ) u_row_mem (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (item_col),
        .rd_data (above_byte),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data)
    );

    psu_recon #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_BPP   (MAX_BYTES_PER_PIXEL)
    ) u_recon (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .load            (accept),
        .in_byte         (s_data_byte),
        .in_ctrl         (item_ctrl),
        .in_col          (item_col),
        .in_slot         (item_slot),
        .above_byte      (above_byte),
        .stage_free      (stage_free),
        .stage_busy      (stage_busy),
        .wr_en           (wr_en),
        .wr_addr         (wr_addr),
        .wr_data         (wr_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_byte    (m_pixel_byte),
        .m_end_of_row    (m_end_of_row),
        .m_last_of_image (m_last_of_image)
    );

    // The last byte of an image always closes a row
    a_last_ends_row: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_end_of_row || !m_last_of_image))
        else $error("last_of_image without end_of_row");

    // Row store never reads and writes the same column at one edge
    a_no_rw_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_en && wr_en) |-> (item_col != wr_addr))
        else $error("row store read/write collision");

    // An accepted transaction occupies the reconstruction stage on the next cycle
    a_accept_fills_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> stage_busy)
        else $error("accepted transaction lost before reconstruction");

endmodule
